// ----- sv/threshold_gallop_bisect_search_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the threshold search block
// Shared concurrent check forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_GALLOP_BISECT_SEARCH_MACROS_SVH
`define THRESHOLD_GALLOP_BISECT_SEARCH_MACROS_SVH

// same-cycle implication
`define TGBS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGBS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tgbs_pkg.sv -----
// ---------------------------------------------------------------------------
// tgbs_pkg
// Event codes, field widths and flag structs of the threshold search block.
// ---------------------------------------------------------------------------
package tgbs_pkg;

  localparam int MODE_W  = 2;
  localparam int LEVEL_W = 32;
  localparam int FIELD_W = 32;

  // result word: candidate, three flags, upper, lower, preview
  localparam int OUT_FIELDS_W = 4 * FIELD_W + 3;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [MODE_W-1:0] MODE_NEXT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SATURATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SATISFY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FINISH   = 2'd3;

  // per-round search flags
  typedef struct packed {
    logic first;   // known high bound not yet probed
    logic lk;      // low bound known
    logic lchk;    // low bound revalidated
    logic hk;      // high bound known
  } view_flags_t;

  // all flag state of the controller
  typedef struct packed {
    logic        in_round;
    logic        best_sat_known;
    logic        best_satur_known;
    view_flags_t rv;
  } state_flags_t;

endpackage

// ----- sv/tgbs_seed.sv -----
// ---------------------------------------------------------------------------
// tgbs_seed
// Selects the round view: the live round, or a fresh one seeded from the
// cross-round best levels when no round is open.
// ---------------------------------------------------------------------------
module tgbs_seed #(
  parameter int INDEX_WIDTH = 32
) (
  input  tgbs_pkg::state_flags_t  flags,
  input  logic [INDEX_WIDTH-1:0]  best_sat,
  input  logic [INDEX_WIDTH-1:0]  best_satur,
  input  logic [INDEX_WIDTH-1:0]  lo,
  input  logic [INDEX_WIDTH-1:0]  hi,
  input  logic [INDEX_WIDTH-1:0]  step,
  output tgbs_pkg::view_flags_t   eff_flags,
  output logic [INDEX_WIDTH-1:0]  eff_lo,
  output logic [INDEX_WIDTH-1:0]  eff_hi,
  output logic [INDEX_WIDTH-1:0]  eff_step
);

  logic [INDEX_WIDTH-1:0] seed_lo;
  logic [INDEX_WIDTH-1:0] seed_hi;

  assign seed_lo = flags.best_satur_known ? best_satur : '0;
  assign seed_hi = flags.best_sat_known ? best_sat : '0;

  always_comb begin
    if (flags.in_round) begin
      eff_flags = flags.rv;
      eff_lo    = lo;
      eff_hi    = hi;
      eff_step  = step;
    end else begin
      eff_flags.first = 1'b1;
      eff_flags.lk    = flags.best_satur_known;
      eff_flags.lchk  = (seed_lo == '0);
      // drop a high bound that is not above the low bound
      eff_flags.hk    = flags.best_sat_known &&
                        !(flags.best_satur_known && (seed_hi <= seed_lo));
      eff_lo          = seed_lo;
      eff_hi          = seed_hi;
      eff_step        = INDEX_WIDTH'(1);
    end
  end

endmodule

// ----- sv/tgbs_pick.sv -----
// ---------------------------------------------------------------------------
// tgbs_pick
// Candidate selection: probe high bound, revalidate low bound, bisect, or
// gallop upward with a doubling, saturating step.
// ---------------------------------------------------------------------------
module tgbs_pick #(
  parameter int INDEX_WIDTH = 32
) (
  input  tgbs_pkg::view_flags_t   vf,
  input  logic [INDEX_WIDTH-1:0]  lo,
  input  logic [INDEX_WIDTH-1:0]  hi,
  input  logic [INDEX_WIDTH-1:0]  step,
  output logic [INDEX_WIDTH-1:0]  cand,
  output logic [INDEX_WIDTH-1:0]  step_next
);

  logic [INDEX_WIDTH:0]   lo_inc;
  logic [INDEX_WIDTH-1:0] lo_p1;
  logic [INDEX_WIDTH-1:0] base;
  logic [INDEX_WIDTH:0]   gal_sum;
  logic [INDEX_WIDTH-1:0] gal;
  logic [INDEX_WIDTH-1:0] step_dbl;
  logic [INDEX_WIDTH-1:0] mid;

  assign lo_inc   = {1'b0, lo} + (INDEX_WIDTH+1)'(1);
  assign lo_p1    = lo_inc[INDEX_WIDTH] ? '1 : lo_inc[INDEX_WIDTH-1:0];
  assign base     = vf.lk ? lo : '0;
  // step is never zero, so a saturated sum is the only case at or below base
  assign gal_sum  = {1'b0, base} + {1'b0, step};
  assign gal      = gal_sum[INDEX_WIDTH] ? '1 : gal_sum[INDEX_WIDTH-1:0];
  assign step_dbl = step[INDEX_WIDTH-1] ? '1 : {step[INDEX_WIDTH-2:0], 1'b0};
  // only used when hi exceeds lo by two or more, so mid lies strictly between
  assign mid      = lo + ((hi - lo) >> 1);

  always_comb begin
    step_next = step;
    if (vf.first && vf.hk) begin
      cand = hi;
    end else if (vf.hk && vf.lk && !vf.lchk) begin
      cand = lo;
    end else if (vf.hk && vf.lk) begin
      cand = (lo_p1 >= hi) ? hi : mid;
    end else begin
      cand      = gal;
      step_next = step_dbl;
    end
  end

endmodule

// ----- sv/tgbs_update.sv -----
// ---------------------------------------------------------------------------
// tgbs_update
// Applies one event to the controller state and forms the request candidate.
// ---------------------------------------------------------------------------
module tgbs_update #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic [tgbs_pkg::MODE_W-1:0] mode,
  input  logic [INDEX_WIDTH-1:0]      level,
  input  tgbs_pkg::state_flags_t      flags,
  input  logic [INDEX_WIDTH-1:0]      best_sat,
  input  logic [INDEX_WIDTH-1:0]      best_satur,
  input  logic [INDEX_WIDTH-1:0]      lo,
  input  logic [INDEX_WIDTH-1:0]      hi,
  input  logic [INDEX_WIDTH-1:0]      step,
  output tgbs_pkg::state_flags_t      flags_next,
  output logic [INDEX_WIDTH-1:0]      best_sat_next,
  output logic [INDEX_WIDTH-1:0]      best_satur_next,
  output logic [INDEX_WIDTH-1:0]      lo_next,
  output logic [INDEX_WIDTH-1:0]      hi_next,
  output logic [INDEX_WIDTH-1:0]      step_next,
  output logic [INDEX_WIDTH-1:0]      cand
);

  tgbs_pkg::view_flags_t  eff_flags;
  logic [INDEX_WIDTH-1:0] eff_lo;
  logic [INDEX_WIDTH-1:0] eff_hi;
  logic [INDEX_WIDTH-1:0] eff_step;
  logic [INDEX_WIDTH-1:0] pick_cand;
  logic [INDEX_WIDTH-1:0] pick_step;
  logic [INDEX_WIDTH-1:0] raise_lo;

  tgbs_seed #(.INDEX_WIDTH(INDEX_WIDTH)) u_seed (
    .flags      (flags),
    .best_sat   (best_sat),
    .best_satur (best_satur),
    .lo         (lo),
    .hi         (hi),
    .step       (step),
    .eff_flags  (eff_flags),
    .eff_lo     (eff_lo),
    .eff_hi     (eff_hi),
    .eff_step   (eff_step)
  );

  tgbs_pick #(.INDEX_WIDTH(INDEX_WIDTH)) u_pick (
    .vf        (eff_flags),
    .lo        (eff_lo),
    .hi        (eff_hi),
    .step      (eff_step),
    .cand      (pick_cand),
    .step_next (pick_step)
  );

  // low bound after a saturating report
  assign raise_lo = (!flags.rv.lk || (level > lo)) ? level : lo;

  always_comb begin
    flags_next      = flags;
    best_sat_next   = best_sat;
    best_satur_next = best_satur;
    lo_next         = lo;
    hi_next         = hi;
    step_next       = step;
    cand            = '0;
    unique case (mode)
      tgbs_pkg::MODE_NEXT: begin
        flags_next.in_round = 1'b1;
        flags_next.rv       = eff_flags;
        flags_next.rv.first = 1'b0;
        lo_next             = eff_lo;
        hi_next             = eff_hi;
        step_next           = pick_step;
        cand                = pick_cand;
      end
      tgbs_pkg::MODE_SATURATE: begin
        if (!flags.best_satur_known || (level > best_satur)) begin
          best_satur_next = level;
        end
        flags_next.best_satur_known = 1'b1;
        if (flags.in_round) begin
          // any saturating report in a round leaves the low bound known
          lo_next          = raise_lo;
          flags_next.rv.lk = 1'b1;
          if (level == raise_lo) begin
            flags_next.rv.lchk = 1'b1;
          end
          if (flags.rv.hk && (level >= hi)) begin
            flags_next.rv.hk = 1'b0;
          end
        end
      end
      tgbs_pkg::MODE_SATISFY: begin
        if (!flags.best_sat_known || (level < best_sat)) begin
          best_sat_next = level;
        end
        flags_next.best_sat_known = 1'b1;
        if (flags.in_round) begin
          hi_next          = level;
          flags_next.rv.hk = 1'b1;
          step_next        = INDEX_WIDTH'(1);
          if (!flags.rv.lk || (lo >= level)) begin
            if (level == '0) begin
              flags_next.rv.lk   = 1'b0;
              lo_next            = '0;
              flags_next.rv.lchk = 1'b1;
            end else begin
              flags_next.rv.lk   = 1'b1;
              lo_next            = level - INDEX_WIDTH'(1);
              flags_next.rv.lchk = (level == INDEX_WIDTH'(1));
            end
          end
        end
      end
      tgbs_pkg::MODE_FINISH: begin
        flags_next.in_round = 1'b0;
      end
      default: begin
        flags_next = flags;
      end
    endcase
  end

endmodule

// ----- sv/tgbs_result.sv -----
// ---------------------------------------------------------------------------
// tgbs_result
// Derives the refinement flag and the preview candidate from a state copy.
// ---------------------------------------------------------------------------
module tgbs_result #(
  parameter int INDEX_WIDTH = 32
) (
  input  tgbs_pkg::state_flags_t  flags,
  input  logic [INDEX_WIDTH-1:0]  best_sat,
  input  logic [INDEX_WIDTH-1:0]  best_satur,
  input  logic [INDEX_WIDTH-1:0]  lo,
  input  logic [INDEX_WIDTH-1:0]  hi,
  input  logic [INDEX_WIDTH-1:0]  step,
  output logic                    refine,
  output logic [INDEX_WIDTH-1:0]  preview
);

  tgbs_pkg::view_flags_t  eff_flags;
  logic [INDEX_WIDTH-1:0] eff_lo;
  logic [INDEX_WIDTH-1:0] eff_hi;
  logic [INDEX_WIDTH-1:0] eff_step;
  logic [INDEX_WIDTH-1:0] unused_step;
  logic [INDEX_WIDTH:0]   lo_inc;
  logic [INDEX_WIDTH-1:0] lo_p1;

  tgbs_seed #(.INDEX_WIDTH(INDEX_WIDTH)) u_seed (
    .flags      (flags),
    .best_sat   (best_sat),
    .best_satur (best_satur),
    .lo         (lo),
    .hi         (hi),
    .step       (step),
    .eff_flags  (eff_flags),
    .eff_lo     (eff_lo),
    .eff_hi     (eff_hi),
    .eff_step   (eff_step)
  );

  // preview runs the same pick on a throwaway view
  tgbs_pick #(.INDEX_WIDTH(INDEX_WIDTH)) u_pick (
    .vf        (eff_flags),
    .lo        (eff_lo),
    .hi        (eff_hi),
    .step      (eff_step),
    .cand      (preview),
    .step_next (unused_step)
  );

  assign lo_inc = {1'b0, lo} + (INDEX_WIDTH+1)'(1);
  assign lo_p1  = lo_inc[INDEX_WIDTH] ? '1 : lo_inc[INDEX_WIDTH-1:0];

  always_comb begin
    if (!flags.in_round) begin
      refine = 1'b0;
    end else if (!flags.rv.hk || !flags.rv.lk || !flags.rv.lchk) begin
      refine = 1'b1;
    end else begin
      refine = (lo_p1 < hi) || (unused_step == '0);
    end
  end

endmodule

// ----- sv/threshold_gallop_bisect_search.sv -----
// ---------------------------------------------------------------------------
// threshold_gallop_bisect_search
// Threshold index search controller: gallop upward, then bisect between the
// remembered saturating and satisfying levels.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake          tdata (low bit up)          tuser
//   -------   ---  -----------------  --------------------------  -----
//   s_axis    in   s_tvalid/s_tready  level[31:0]                 mode[1:0]
//   m_axis    out  m_tvalid/m_tready  candidate, round_active,    none
//                                     needs_refinement, has_upper,
//                                     upper_bound, lower_bound,
//                                     preview_candidate, 5 pad bits
//
// One event per cycle sustained while m_tready stays high; each event leaves as
// one result word after it passes the input register, the state register and
// the result register. The event update (a saturating add, a halving add and a
// few compares on the registered bounds) is the longest path.
// rst clears the search state to its idle values and empties all stages.
// While the result waits on m_tready, up to two further events are taken
// into the input and state stages before s_tready drops.
// ---------------------------------------------------------------------------
`include "threshold_gallop_bisect_search_macros.svh"

module threshold_gallop_bisect_search #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tgbs_pkg::LEVEL_W-1:0]        s_tdata,   // level
  input  logic [tgbs_pkg::MODE_W-1:0]         s_tuser,   // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // candidate, round_active, needs_refinement, has_upper, upper_bound,
  // lower_bound, preview_candidate, zero pad
  output logic [tgbs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // input stage
  logic                          a_valid;
  logic [tgbs_pkg::MODE_W-1:0]   a_mode;
  logic [INDEX_WIDTH-1:0]        a_level;

  // live search state
  tgbs_pkg::state_flags_t        flags;
  logic [INDEX_WIDTH-1:0]        best_sat;
  logic [INDEX_WIDTH-1:0]        best_satur;
  logic [INDEX_WIDTH-1:0]        lo;
  logic [INDEX_WIDTH-1:0]        hi;
  logic [INDEX_WIDTH-1:0]        step;

  tgbs_pkg::state_flags_t        flags_next;
  logic [INDEX_WIDTH-1:0]        best_sat_next;
  logic [INDEX_WIDTH-1:0]        best_satur_next;
  logic [INDEX_WIDTH-1:0]        lo_next;
  logic [INDEX_WIDTH-1:0]        hi_next;
  logic [INDEX_WIDTH-1:0]        step_next;
  logic [INDEX_WIDTH-1:0]        cand_next;

  // state copy stage: candidate plus the state just after the event
  logic                          b_valid;
  logic [INDEX_WIDTH-1:0]        b_cand;
  tgbs_pkg::state_flags_t        b_flags;
  logic [INDEX_WIDTH-1:0]        b_best_sat;
  logic [INDEX_WIDTH-1:0]        b_best_satur;
  logic [INDEX_WIDTH-1:0]        b_lo;
  logic [INDEX_WIDTH-1:0]        b_hi;
  logic [INDEX_WIDTH-1:0]        b_step;

  logic                          b_refine;
  logic [INDEX_WIDTH-1:0]        b_preview;

  logic                          c_take;
  logic                          b_free;
  logic                          a_adv;

  // stage flow: each stage loads when the one after it has room
  assign c_take   = !m_tvalid || m_tready;
  assign b_free   = !b_valid || c_take;
  assign a_adv    = a_valid && b_free;
  assign s_tready = !a_valid || b_free;

  // capture the event; levels wider than the index keep their low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_mode  <= s_tuser;
      a_level <= INDEX_WIDTH'(s_tdata);
    end
  end

  tgbs_update #(.INDEX_WIDTH(INDEX_WIDTH)) u_update (
    .mode            (a_mode),
    .level           (a_level),
    .flags           (flags),
    .best_sat        (best_sat),
    .best_satur      (best_satur),
    .lo              (lo),
    .hi              (hi),
    .step            (step),
    .flags_next      (flags_next),
    .best_sat_next   (best_sat_next),
    .best_satur_next (best_satur_next),
    .lo_next         (lo_next),
    .hi_next         (hi_next),
    .step_next       (step_next),
    .cand            (cand_next)
  );

  // apply each event exactly once, as it moves into the copy stage
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.in_round         <= 1'b0;
      flags.best_sat_known   <= 1'b0;
      flags.best_satur_known <= 1'b0;
      flags.rv.first         <= 1'b1;
      flags.rv.lk            <= 1'b0;
      flags.rv.lchk          <= 1'b1;
      flags.rv.hk            <= 1'b0;
      best_sat               <= '0;
      best_satur             <= '0;
      lo                     <= '0;
      hi                     <= '0;
      step                   <= INDEX_WIDTH'(1);
    end else if (a_adv) begin
      flags      <= flags_next;
      best_sat   <= best_sat_next;
      best_satur <= best_satur_next;
      lo         <= lo_next;
      hi         <= hi_next;
      step       <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  // hold a private copy so later events cannot disturb this result
  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_cand       <= cand_next;
      b_flags      <= flags_next;
      b_best_sat   <= best_sat_next;
      b_best_satur <= best_satur_next;
      b_lo         <= lo_next;
      b_hi         <= hi_next;
      b_step       <= step_next;
    end
  end

  tgbs_result #(.INDEX_WIDTH(INDEX_WIDTH)) u_result (
    .flags      (b_flags),
    .best_sat   (b_best_sat),
    .best_satur (b_best_satur),
    .lo         (b_lo),
    .hi         (b_hi),
    .step       (b_step),
    .refine     (b_refine),
    .preview    (b_preview)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c_take) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take && b_valid) begin
      m_tdata <= {{tgbs_pkg::OUT_PAD_W{1'b0}},
                  tgbs_pkg::FIELD_W'(b_preview),
                  tgbs_pkg::FIELD_W'(b_lo),
                  tgbs_pkg::FIELD_W'(b_hi),
                  b_flags.rv.hk,
                  b_refine,
                  b_flags.in_round,
                  tgbs_pkg::FIELD_W'(b_cand)};
    end
  end

  // the gallop step never collapses to zero
  `TGBS_CHECK(a_step_nonzero, 1'b1, step != '0, "gallop step reached zero")
  // input side only stalls behind a stalled result
  `TGBS_CHECK(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without cause")
  // inside a round a known high bound stays above a known low bound
  `TGBS_CHECK(a_bound_order, flags.in_round && flags.rv.hk && flags.rv.lk, hi > lo, "bounds crossed")
  // a satisfying report in a round always sets the high bound
  `TGBS_CHECK_NEXT(a_satisfy_high, a_adv && (a_mode == tgbs_pkg::MODE_SATISFY) && flags.in_round, flags.rv.hk && (hi == $past(a_level)), "satisfy did not set high bound")
  // finishing closes the round
  `TGBS_CHECK_NEXT(a_finish_close, a_adv && (a_mode == tgbs_pkg::MODE_FINISH), !flags.in_round, "round still open after finish")

endmodule
